>>> src/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

   localparam int SENSOR_COUNT = 5;

   localparam logic [1:0] CMD_STEP  = 2'd0;
   localparam logic [1:0] CMD_PULSE = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   localparam logic [1:0] POS_CENTRE = 2'd0;
   localparam logic [1:0] POS_RIGHT  = 2'd1;
   localparam logic [1:0] POS_LEFT   = 2'd2;
   localparam logic [1:0] POS_LOST   = 2'd3;

   localparam logic [2:0] CSR_SHORT_LIMIT = 3'd0;
   localparam logic [2:0] CSR_MID_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_LONG_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_ADVANCE_MIN = 3'd3;
   localparam logic [2:0] CSR_LEFT_GAIN   = 3'd4;
   localparam logic [2:0] CSR_RIGHT_GAIN  = 3'd5;

   localparam logic [2:0] SEG_IDLE  = 3'd0;
   localparam logic [2:0] SEG_FIRST = 3'd1;
   localparam logic [2:0] SEG_LAST  = 3'd7;

   localparam logic [9:0] PULSE_MAX = 10'd1023;

   localparam logic [11:0] START_LEFT  = 12'd2000;
   localparam logic [11:0] START_RIGHT = 12'd3500;

   localparam int GAIN_FRAC_BITS = 10;

   typedef struct packed {
      logic [1:0]              command;
      logic [SENSOR_COUNT-1:0] line_sensors;
   } req_word_type;

   typedef struct packed {
      logic [12:0] left_drive;
      logic [12:0] right_drive;
      logic [2:0]  segment;
   } rsp_word_type;

   typedef struct packed {
      logic [11:0] left_base;
      logic [11:0] right_base;
      logic [1:0]  last_position;
      logic [1:0]  remembered_side;
   } steer_state_type;

   typedef struct packed {
      logic [2:0]      segment;
      logic [9:0]      pulse_count;
      steer_state_type steer;
   } seq_state_type;

   typedef struct packed {
      logic [9:0] short_pulse_limit;
      logic [9:0] mid_pulse_limit;
      logic [9:0] long_pulse_limit;
      logic [9:0] advance_min_pulses;
   } limit_cfg_type;

endpackage

>>> src/lfs_steer.sv
`timescale 1ns / 1ps

module lfs_steer (
   input  lfs_pkg::seq_state_type state,
   input  lfs_pkg::req_word_type  req_word,
   input  lfs_pkg::limit_cfg_type limits,
   output lfs_pkg::seq_state_type state_next
);
   import lfs_pkg::*;

   function automatic steer_state_type with_base(steer_state_type st, logic [11:0] l,
                                                 logic [11:0] r);
      steer_state_type o;
      o = st;
      o.left_base = l;
      o.right_base = r;
      return o;
   endfunction

   function automatic steer_state_type gentle_table(steer_state_type st, logic [4:0] s);
      steer_state_type o;
      logic [1:0] p;
      o = st;
      p = o.last_position;
      if (s == 5'h1f) begin
         if (p != POS_LOST) begin
            if (p == POS_LEFT) begin
               o = with_base(o, 12'd1300, 12'd1400);
               o.remembered_side = POS_LEFT;
            end
            o.last_position = POS_LOST;
         end else if (o.remembered_side == POS_LEFT) begin
            o = with_base(o, 12'd1300, 12'd1400);
         end
      end else if (!s[3]) begin
         if (!s[4]) begin
            o = with_base(o, 12'd1200, 12'd1400);
         end else if (p == POS_CENTRE || p == POS_RIGHT) begin
            o = with_base(o, 12'd1200, 12'd1400);
            o.remembered_side = POS_CENTRE;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1200, 12'd1400);
         end
      end
      p = o.last_position;
      if (!s[4]) begin
         if (p != POS_RIGHT) begin
            if (p == POS_CENTRE) begin
               o = with_base(o, 12'd1300, 12'd1400);
               o.remembered_side = POS_CENTRE;
            end else if (p == POS_LOST) begin
               o = with_base(o, 12'd1300, 12'd1400);
               o.remembered_side = POS_LOST;
            end
            o.last_position = POS_RIGHT;
         end else if (o.remembered_side == POS_CENTRE || o.remembered_side == POS_LOST) begin
            o = with_base(o, 12'd1300, 12'd1400);
         end
      end else if (!s[2]) begin
         o = with_base(o, 12'd1125, 12'd1475);
         o.last_position = POS_CENTRE;
      end
      return o;
   endfunction

   function automatic steer_state_type sharp_table(steer_state_type st, logic [4:0] s);
      steer_state_type o;
      logic [1:0] p;
      o = st;
      p = o.last_position;
      if (s == 5'h1f) begin
         if (p != POS_LOST) begin
            if (p == POS_RIGHT) begin
               o = with_base(o, 12'd1350, 12'd0);
               o.remembered_side = POS_RIGHT;
            end else if (p == POS_LEFT) begin
               o = with_base(o, 12'd1350, 12'd0);
               o.remembered_side = POS_LEFT;
            end
            o.last_position = POS_LOST;
         end else if (o.remembered_side == POS_RIGHT) begin
            o = with_base(o, 12'd1350, 12'd0);
         end else if (o.remembered_side == POS_LEFT) begin
            o = with_base(o, 12'd0, 12'd1350);
         end
      end
      p = o.last_position;
      if (!s[1]) begin
         if (!s[0]) begin
            o = with_base(o, 12'd1125, 12'd1275);
         end else if (p == POS_CENTRE || p == POS_LEFT) begin
            o = with_base(o, 12'd1125, 12'd1275);
            o.remembered_side = POS_CENTRE;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1125, 12'd1275);
         end
      end else if (!s[3]) begin
         if (!s[4]) begin
            o = with_base(o, 12'd1125, 12'd1275);
         end else if (p == POS_CENTRE || p == POS_RIGHT) begin
            o = with_base(o, 12'd1275, 12'd1125);
            o.remembered_side = POS_CENTRE;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1275, 12'd1125);
         end
      end
      if (!s[4]) begin
         if (p != POS_RIGHT) begin
            if (p == POS_CENTRE) begin
               o = with_base(o, 12'd1350, 12'd0);
               o.remembered_side = POS_CENTRE;
            end else if (p == POS_LOST) begin
               o = with_base(o, 12'd1350, 12'd1100);
               o.remembered_side = POS_LOST;
            end
            o.last_position = POS_RIGHT;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1350, 12'd0);
         end else if (o.remembered_side == POS_LOST) begin
            o = with_base(o, 12'd1350, 12'd1100);
         end
      end else if (!s[0]) begin
         if (p != POS_LEFT) begin
            if (p == POS_CENTRE) begin
               o = with_base(o, 12'd0, 12'd1350);
               o.remembered_side = POS_CENTRE;
            end else if (p == POS_LOST) begin
               o = with_base(o, 12'd1100, 12'd1350);
            end
            o.last_position = POS_LEFT;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd0, 12'd1350);
         end else if (o.remembered_side == POS_LOST) begin
            o = with_base(o, 12'd1100, 12'd1350);
         end
      end else if (!s[2]) begin
         o = with_base(o, 12'd1225, 12'd1275);
         o.last_position = POS_CENTRE;
      end
      return o;
   endfunction

   function automatic steer_state_type normal_table(steer_state_type st, logic [4:0] s);
      steer_state_type o;
      logic [1:0] p;
      o = st;
      p = o.last_position;
      if (s == 5'h1f) begin
         if (p != POS_LOST) begin
            if (p == POS_RIGHT) begin
               o = with_base(o, 12'd1550, 12'd1100);
               o.remembered_side = POS_RIGHT;
            end else if (p == POS_LEFT) begin
               o = with_base(o, 12'd1200, 12'd1550);
               o.remembered_side = POS_LEFT;
            end
            o.last_position = POS_LOST;
         end else if (o.remembered_side == POS_RIGHT) begin
            o = with_base(o, 12'd1550, 12'd1100);
         end else if (o.remembered_side == POS_LEFT) begin
            o = with_base(o, 12'd1200, 12'd1550);
         end
      end
      p = o.last_position;
      if (!s[1]) begin
         if (!s[0]) begin
            o = with_base(o, 12'd1400, 12'd1500);
         end else if (p == POS_CENTRE || p == POS_LEFT) begin
            o = with_base(o, 12'd1400, 12'd1500);
            o.remembered_side = POS_CENTRE;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1400, 12'd1500);
         end
      end else if (!s[3]) begin
         if (!s[4]) begin
            o = with_base(o, 12'd1350, 12'd1500);
         end else if (p == POS_CENTRE || p == POS_RIGHT) begin
            o = with_base(o, 12'd1500, 12'd1350);
            o.remembered_side = POS_CENTRE;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1500, 12'd1350);
         end
      end
      if (!s[4]) begin
         if (p != POS_RIGHT) begin
            if (p == POS_CENTRE) begin
               o = with_base(o, 12'd1575, 12'd1100);
               o.remembered_side = POS_CENTRE;
            end else if (p == POS_LOST) begin
               o = with_base(o, 12'd1575, 12'd1200);
               o.remembered_side = POS_LOST;
            end
            o.last_position = POS_RIGHT;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1575, 12'd1100);
         end else if (o.remembered_side == POS_LOST) begin
            o = with_base(o, 12'd1575, 12'd1200);
         end
      end else if (!s[0]) begin
         if (p != POS_LEFT) begin
            if (p == POS_CENTRE) begin
               o = with_base(o, 12'd1200, 12'd1575);
               o.remembered_side = POS_CENTRE;
            end else if (p == POS_LOST) begin
               o = with_base(o, 12'd1300, 12'd1575);
            end
            o.last_position = POS_LEFT;
         end else if (o.remembered_side == POS_CENTRE) begin
            o = with_base(o, 12'd1200, 12'd1575);
         end else if (o.remembered_side == POS_LOST) begin
            o = with_base(o, 12'd1300, 12'd1575);
         end
      end else if (!s[2]) begin
         o = with_base(o, 12'd1425, 12'd1475);
         o.last_position = POS_CENTRE;
      end
      return o;
   endfunction

   logic [SENSOR_COUNT-1:0] sensors;
   logic                    crossing;
   steer_state_type         steered;

   assign sensors = req_word.line_sensors;
   assign crossing = (!sensors[4] || !sensors[3]) && !sensors[2]
                     && (!sensors[0] || !sensors[1]);

   always_comb begin
      case (state.segment)
         3'd1, 3'd3, 3'd6: begin
            if (state.pulse_count < limits.short_pulse_limit) begin
               steered = gentle_table(state.steer, sensors);
            end else begin
               steered = normal_table(state.steer, sensors);
            end
         end
         3'd2: begin
            if (state.pulse_count < limits.mid_pulse_limit) begin
               steered = normal_table(state.steer, sensors);
            end else begin
               steered = gentle_table(state.steer, sensors);
            end
         end
         3'd4: begin
            if (state.pulse_count < limits.long_pulse_limit) begin
               steered = gentle_table(state.steer, sensors);
            end else begin
               steered = sharp_table(state.steer, sensors);
            end
         end
         3'd5: begin
            steered = sharp_table(state.steer, sensors);
         end
         default: begin
            steered = state.steer;
         end
      endcase
   end

   always_comb begin
      state_next = state;
      case (req_word.command)
         CMD_START: begin
            state_next.segment = SEG_FIRST;
            state_next.pulse_count = '0;
            state_next.steer = with_base(state.steer, START_LEFT, START_RIGHT);
         end
         CMD_PULSE: begin
            if (state.pulse_count < PULSE_MAX) begin
               state_next.pulse_count = state.pulse_count + 10'd1;
            end
         end
         CMD_STEP: begin
            if (state.segment != SEG_IDLE) begin
               state_next.steer = steered;
               if (crossing && state.pulse_count > limits.advance_min_pulses) begin
                  if (state.segment < SEG_LAST) begin
                     state_next.segment = state.segment + 3'd1;
                  end
                  state_next.pulse_count = '0;
               end
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

>>> src/lfs_scale.sv
`timescale 1ns / 1ps

module lfs_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  logic [11:0]            left_base,
   input  logic [11:0]            right_base,
   input  logic [2:0]             segment,
   input  logic [10:0]            left_gain_q10,
   input  logic [10:0]            right_gain_q10,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lfs_pkg::rsp_word_type  rsp_word
);
   import lfs_pkg::*;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic [22:0]  left_product;
   logic [22:0]  right_product;

   assign load_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = load_ready ? load_valid : rsp_valid_ff;

   assign left_product = {11'd0, left_base} * {12'd0, left_gain_q10};
   assign right_product = {11'd0, right_base} * {12'd0, right_gain_q10};

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (load_ready && load_valid) begin
         rsp_word_in.left_drive = left_product[GAIN_FRAC_BITS +: 13];
         rsp_word_in.right_drive = right_product[GAIN_FRAC_BITS +: 13];
         rsp_word_in.segment = segment;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

>>> src/line_follow_steering_sequencer.sv
`timescale 1ns / 1ps

// Line follower steering sequencer. Each request word is a start, an encoder pulse, a
// control step with five line-sensor bits or an unused code that changes nothing, and each
// produces exactly one response word with the left and right drives (base speed times Q10
// gain, shifted down ten bits) and the track segment after that command. The sequencer state
// register is loaded when a word is accepted, and the two gain multipliers fill the response
// register from it when it has room, so one word can be accepted every cycle while the
// response side keeps up. The six configuration registers are written through the csr
// channel, which is always ready, and should only be written while no word is in flight.
module line_follow_steering_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lfs_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lfs_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [10:0]           csr_data
);
   import lfs_pkg::*;

   limit_cfg_type limits_ff;
   logic [10:0]   left_gain_ff;
   logic [10:0]   right_gain_ff;

   seq_state_type state_ff;
   seq_state_type state_in;
   seq_state_type state_next;
   logic          stage_valid_ff;
   logic          stage_valid_in;
   logic          load_ready;
   logic          req_accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.short_pulse_limit <= 10'd20;
         limits_ff.mid_pulse_limit <= 10'd80;
         limits_ff.long_pulse_limit <= 10'd140;
         limits_ff.advance_min_pulses <= 10'd10;
         left_gain_ff <= 11'd1101;
         right_gain_ff <= 11'd1203;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SHORT_LIMIT: limits_ff.short_pulse_limit <= csr_data[9:0];
            CSR_MID_LIMIT:   limits_ff.mid_pulse_limit <= csr_data[9:0];
            CSR_LONG_LIMIT:  limits_ff.long_pulse_limit <= csr_data[9:0];
            CSR_ADVANCE_MIN: limits_ff.advance_min_pulses <= csr_data[9:0];
            CSR_LEFT_GAIN:   left_gain_ff <= csr_data;
            CSR_RIGHT_GAIN:  right_gain_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !stage_valid_ff || load_ready;
   assign req_accept = req_valid && req_ready;

   lfs_steer u_steer (
      .state      (state_ff),
      .req_word   (req_word),
      .limits     (limits_ff),
      .state_next (state_next)
   );

   assign state_in = req_accept ? state_next : state_ff;
   assign stage_valid_in = req_accept || (stage_valid_ff && !load_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   lfs_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (stage_valid_ff),
      .left_base      (state_ff.steer.left_base),
      .right_base     (state_ff.steer.right_base),
      .segment        (state_ff.segment),
      .left_gain_q10  (left_gain_ff),
      .right_gain_q10 (right_gain_ff),
      .load_ready     (load_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word)
   );

   a_start_enters_first: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.command == CMD_START |=> state_ff.segment == SEG_FIRST)
      else $error("start did not put the sequencer on the first segment");

   a_segment_no_backstep: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.command != CMD_START |=> state_ff.segment >= $past(state_ff.segment))
      else $error("segment moved backwards without a start");

   a_pulse_counts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.command == CMD_PULSE && state_ff.pulse_count != PULSE_MAX
      |=> state_ff.pulse_count == $past(state_ff.pulse_count) + 10'd1)
      else $error("encoder pulse not counted");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !load_ready |=> stage_valid_ff && $stable(state_ff))
      else $error("state changed while its response word was stalled");

   a_ready_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && rsp_valid && !rsp_ready)
      else $error("request side stalled with room in the pipeline");

endmodule

>>> bench/tb_line_follow_steering_sequencer.sv
`timescale 1ns / 1ps

module tb_line_follow_steering_sequencer;
   import lfs_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [4:0] NO_LINE = 5'h1f;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int WORDS_PER_PHASE = 20;
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [10:0] csr_data = '0;

   line_follow_steering_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the sequencer state and its registers.
   logic [2:0] track_seg;
   logic [9:0] pulse_cnt;
   logic [1:0] line_pos;
   logic [1:0] side_mem;
   logic [11:0] left_speed;
   logic [11:0] right_speed;
   logic [9:0] short_limit;
   logic [9:0] mid_limit;
   logic [9:0] long_limit;
   logic [9:0] advance_min;
   logic [10:0] left_gain;
   logic [10:0] right_gain;

   rsp_word_type expected_drives[$];
   rsp_word_type oldest_drive;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int words_sent = 0;
   int responses_checked = 0;
   int gentle_steps = 0;
   int normal_steps = 0;
   int sharp_steps = 0;
   int segment_advances = 0;
   logic [2:0] highest_segment = SEG_IDLE;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_drives.size());
         $display("line_follow_steering_sequencer test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected response: left %0d right %0d segment %0d",
                        rsp_word.left_drive, rsp_word.right_drive, rsp_word.segment);
            end
         end else begin
            oldest_drive = expected_drives.pop_front();
            responses_checked++;
            if (rsp_word.left_drive !== oldest_drive.left_drive
                || rsp_word.right_drive !== oldest_drive.right_drive
                || rsp_word.segment !== oldest_drive.segment) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("response %0d: expected %0d %0d seg %0d, got %0d %0d seg %0d",
                           responses_checked, oldest_drive.left_drive,
                           oldest_drive.right_drive, oldest_drive.segment,
                           rsp_word.left_drive, rsp_word.right_drive, rsp_word.segment);
               end
            end
         end
      end
   end

   task automatic set_speeds(input int left, input int right);
      left_speed = 12'(left);
      right_speed = 12'(right);
   endtask

   task automatic steer_gentle(input logic [4:0] s);
      logic [1:0] pos;
      gentle_steps++;
      pos = line_pos;
      if (s == NO_LINE) begin
         if (pos != POS_LOST) begin
            if (pos == POS_LEFT) begin
               set_speeds(1300, 1400);
               side_mem = POS_LEFT;
            end
            line_pos = POS_LOST;
         end else if (side_mem == POS_LEFT) begin
            set_speeds(1300, 1400);
         end
      end else if (!s[3]) begin
         if (!s[4]) begin
            set_speeds(1200, 1400);
         end else if (pos == POS_CENTRE || pos == POS_RIGHT) begin
            set_speeds(1200, 1400);
            side_mem = POS_CENTRE;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1200, 1400);
         end
      end
      pos = line_pos;
      if (!s[4]) begin
         if (pos != POS_RIGHT) begin
            if (pos == POS_CENTRE) begin
               set_speeds(1300, 1400);
               side_mem = POS_CENTRE;
            end else if (pos == POS_LOST) begin
               set_speeds(1300, 1400);
               side_mem = POS_LOST;
            end
            line_pos = POS_RIGHT;
         end else if (side_mem == POS_CENTRE || side_mem == POS_LOST) begin
            set_speeds(1300, 1400);
         end
      end else if (!s[2]) begin
         set_speeds(1125, 1475);
         line_pos = POS_CENTRE;
      end
   endtask

   task automatic steer_sharp(input logic [4:0] s);
      logic [1:0] pos;
      sharp_steps++;
      pos = line_pos;
      if (s == NO_LINE) begin
         if (pos != POS_LOST) begin
            if (pos == POS_RIGHT) begin
               set_speeds(1350, 0);
               side_mem = POS_RIGHT;
            end else if (pos == POS_LEFT) begin
               set_speeds(1350, 0);
               side_mem = POS_LEFT;
            end
            line_pos = POS_LOST;
         end else if (side_mem == POS_RIGHT) begin
            set_speeds(1350, 0);
         end else if (side_mem == POS_LEFT) begin
            set_speeds(0, 1350);
         end
      end
      pos = line_pos;
      if (!s[1]) begin
         if (!s[0]) begin
            set_speeds(1125, 1275);
         end else if (pos == POS_CENTRE || pos == POS_LEFT) begin
            set_speeds(1125, 1275);
            side_mem = POS_CENTRE;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1125, 1275);
         end
      end else if (!s[3]) begin
         if (!s[4]) begin
            set_speeds(1125, 1275);
         end else if (pos == POS_CENTRE || pos == POS_RIGHT) begin
            set_speeds(1275, 1125);
            side_mem = POS_CENTRE;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1275, 1125);
         end
      end
      if (!s[4]) begin
         if (pos != POS_RIGHT) begin
            if (pos == POS_CENTRE) begin
               set_speeds(1350, 0);
               side_mem = POS_CENTRE;
            end else if (pos == POS_LOST) begin
               set_speeds(1350, 1100);
               side_mem = POS_LOST;
            end
            line_pos = POS_RIGHT;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1350, 0);
         end else if (side_mem == POS_LOST) begin
            set_speeds(1350, 1100);
         end
      end else if (!s[0]) begin
         if (pos != POS_LEFT) begin
            if (pos == POS_CENTRE) begin
               set_speeds(0, 1350);
               side_mem = POS_CENTRE;
            end else if (pos == POS_LOST) begin
               set_speeds(1100, 1350);
            end
            line_pos = POS_LEFT;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(0, 1350);
         end else if (side_mem == POS_LOST) begin
            set_speeds(1100, 1350);
         end
      end else if (!s[2]) begin
         set_speeds(1225, 1275);
         line_pos = POS_CENTRE;
      end
   endtask

   task automatic steer_normal(input logic [4:0] s);
      logic [1:0] pos;
      normal_steps++;
      pos = line_pos;
      if (s == NO_LINE) begin
         if (pos != POS_LOST) begin
            if (pos == POS_RIGHT) begin
               set_speeds(1550, 1100);
               side_mem = POS_RIGHT;
            end else if (pos == POS_LEFT) begin
               set_speeds(1200, 1550);
               side_mem = POS_LEFT;
            end
            line_pos = POS_LOST;
         end else if (side_mem == POS_RIGHT) begin
            set_speeds(1550, 1100);
         end else if (side_mem == POS_LEFT) begin
            set_speeds(1200, 1550);
         end
      end
      pos = line_pos;
      if (!s[1]) begin
         if (!s[0]) begin
            set_speeds(1400, 1500);
         end else if (pos == POS_CENTRE || pos == POS_LEFT) begin
            set_speeds(1400, 1500);
            side_mem = POS_CENTRE;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1400, 1500);
         end
      end else if (!s[3]) begin
         if (!s[4]) begin
            set_speeds(1350, 1500);
         end else if (pos == POS_CENTRE || pos == POS_RIGHT) begin
            set_speeds(1500, 1350);
            side_mem = POS_CENTRE;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1500, 1350);
         end
      end
      if (!s[4]) begin
         if (pos != POS_RIGHT) begin
            if (pos == POS_CENTRE) begin
               set_speeds(1575, 1100);
               side_mem = POS_CENTRE;
            end else if (pos == POS_LOST) begin
               set_speeds(1575, 1200);
               side_mem = POS_LOST;
            end
            line_pos = POS_RIGHT;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1575, 1100);
         end else if (side_mem == POS_LOST) begin
            set_speeds(1575, 1200);
         end
      end else if (!s[0]) begin
         if (pos != POS_LEFT) begin
            if (pos == POS_CENTRE) begin
               set_speeds(1200, 1575);
               side_mem = POS_CENTRE;
            end else if (pos == POS_LOST) begin
               set_speeds(1300, 1575);
            end
            line_pos = POS_LEFT;
         end else if (side_mem == POS_CENTRE) begin
            set_speeds(1200, 1575);
         end else if (side_mem == POS_LOST) begin
            set_speeds(1300, 1575);
         end
      end else if (!s[2]) begin
         set_speeds(1425, 1475);
         line_pos = POS_CENTRE;
      end
   endtask

   task automatic steer_and_advance(input logic [4:0] s);
      case (track_seg)
         3'd1, 3'd3, 3'd6: begin
            if (pulse_cnt < short_limit) steer_gentle(s);
            else steer_normal(s);
         end
         3'd2: begin
            if (pulse_cnt < mid_limit) steer_normal(s);
            else steer_gentle(s);
         end
         3'd4: begin
            if (pulse_cnt < long_limit) steer_gentle(s);
            else steer_sharp(s);
         end
         3'd5: steer_sharp(s);
         default: ;
      endcase
      if ((!s[4] || !s[3]) && !s[2] && (!s[0] || !s[1]) && pulse_cnt > advance_min) begin
         if (track_seg != SEG_LAST) begin
            track_seg = track_seg + 3'd1;
            segment_advances++;
         end
         pulse_cnt = '0;
      end
   endtask

   task automatic predict_drives(input req_word_type w);
      rsp_word_type r;
      logic [22:0] left_prod;
      logic [22:0] right_prod;
      case (w.command)
         CMD_START: begin
            track_seg = SEG_FIRST;
            pulse_cnt = '0;
            set_speeds(int'(START_LEFT), int'(START_RIGHT));
         end
         CMD_PULSE: begin
            if (pulse_cnt != PULSE_MAX) pulse_cnt = pulse_cnt + 10'd1;
         end
         CMD_STEP: begin
            if (track_seg != SEG_IDLE) steer_and_advance(w.line_sensors);
         end
         default: ;
      endcase
      left_prod = left_speed * left_gain;
      right_prod = right_speed * right_gain;
      r.left_drive = 13'(left_prod >> GAIN_FRAC_BITS);
      r.right_drive = 13'(right_prod >> GAIN_FRAC_BITS);
      r.segment = track_seg;
      if (track_seg > highest_segment) highest_segment = track_seg;
      expected_drives.push_back(r);
   endtask

   task automatic send_word(input logic [1:0] command, input logic [4:0] sensors);
      req_word_type w;
      w.command = command;
      w.line_sensors = sensors;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      predict_drives(w);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SHORT_LIMIT: short_limit = value[9:0];
         CSR_MID_LIMIT: mid_limit = value[9:0];
         CSR_LONG_LIMIT: long_limit = value[9:0];
         CSR_ADVANCE_MIN: advance_min = value[9:0];
         CSR_LEFT_GAIN: left_gain = value;
         CSR_RIGHT_GAIN: right_gain = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [9:0] short_val, input logic [9:0] mid_val,
                            input logic [9:0] long_val, input logic [9:0] advance_val,
                            input logic [10:0] left_val, input logic [10:0] right_val);
      wait_until_drained();
      write_register(CSR_SHORT_LIMIT, {1'b0, short_val});
      write_register(CSR_MID_LIMIT, {1'b0, mid_val});
      write_register(CSR_LONG_LIMIT, {1'b0, long_val});
      write_register(CSR_ADVANCE_MIN, {1'b0, advance_val});
      write_register(CSR_LEFT_GAIN, left_val);
      write_register(CSR_RIGHT_GAIN, right_val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [4:0] track_pattern();
      logic [4:0] s;
      case ($urandom_range(3))
         0: s = NO_LINE;
         1: s = ~(5'b00001 << $urandom_range(4));
         2: s = ~(5'b00011 << $urandom_range(3));
         default: s = 5'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [4:0] crossing_pattern();
      logic [4:0] s;
      s = 5'($urandom);
      s[2] = 1'b0;
      if ($urandom_range(1)) s[3] = 1'b0;
      else s[4] = 1'b0;
      if ($urandom_range(1)) s[0] = 1'b0;
      else s[1] = 1'b0;
      return s;
   endfunction

   task automatic test_idle_and_unused();
      send_word(CMD_STEP, 5'h00);
      send_word(CMD_PULSE, 5'h00);
      send_word(CMD_UNUSED, 5'h1f);
      send_word(CMD_UNUSED, 5'h00);
      send_word(CMD_START, 5'h1f);
      send_word(CMD_STEP, NO_LINE);
      send_word(CMD_STEP, 5'h1b);
      send_word(CMD_STEP, 5'h0f);
      send_word(CMD_STEP, 5'h1e);
      send_word(CMD_START, 5'h00);
   endtask

   task automatic test_segment_walk();
      configure(10'd2, 10'd1, 10'd2, 10'd0, 11'd2047, 11'd2047);
      send_word(CMD_START, 5'h00);
      repeat (7) begin
         send_word(CMD_PULSE, 5'h00);
         send_word(CMD_STEP, 5'h00);
      end
      send_word(CMD_STEP, NO_LINE);
      send_word(CMD_START, 5'h1f);
   endtask

   task automatic test_pulse_saturation();
      configure(10'd20, 10'd80, 10'd140, 10'd10, 11'd1101, 11'd1203);
      send_word(CMD_START, 5'h00);
      repeat (1030) send_word(CMD_PULSE, 5'($urandom));
      send_word(CMD_STEP, 5'h0f);
      send_word(CMD_STEP, NO_LINE);
      send_word(CMD_STEP, crossing_pattern());
      send_word(CMD_STEP, 5'h1b);
   endtask

   task automatic run_random_words(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         if (track_seg == SEG_IDLE || $urandom_range(99) < 3) begin
            send_word(CMD_START, 5'($urandom));
            sent++;
         end
         pick = $urandom_range(99);
         if (pick < 3) begin
            repeat ($urandom_range(50, 160)) begin
               send_word(CMD_PULSE, 5'($urandom));
               sent++;
            end
         end else if (pick < 33) begin
            repeat ($urandom_range(1, 12)) begin
               send_word(CMD_PULSE, 5'($urandom));
               sent++;
            end
         end else if (pick < 73) begin
            send_word(CMD_STEP, track_pattern());
            sent++;
         end else if (pick < 85) begin
            send_word(CMD_STEP, crossing_pattern());
            sent++;
         end else if (pick < 90) begin
            send_word(2'($urandom), 5'($urandom));
            sent++;
         end else if (pick < 91) begin
            wait_until_drained();
         end else begin
            send_word(CMD_STEP, 5'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(10'd20, 10'd80, 10'd140, 10'd10, 11'd1101, 11'd1203);
            1: configure(10'd0, 10'd0, 10'd0, 10'd0, 11'd0, 11'd0);
            2: configure(10'd1023, 10'd1023, 10'd1023, 10'd1023, 11'd2047, 11'd2047);
            default: configure(10'($urandom_range(40)), 10'($urandom_range(60)),
                               10'($urandom_range(80)), 10'($urandom_range(15)),
                               11'($urandom_range(2047)), 11'($urandom_range(2047)));
         endcase
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 55;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 55;
            end
            default: begin
               send_idle_pct = 29;
               stall_pct = 29;
            end
         endcase
         run_random_words(WORDS_PER_PHASE);
      end
   endtask

   initial begin
      track_seg = SEG_IDLE;
      pulse_cnt = '0;
      line_pos = POS_CENTRE;
      side_mem = POS_CENTRE;
      left_speed = '0;
      right_speed = '0;
      short_limit = 10'd20;
      mid_limit = 10'd80;
      long_limit = 10'd140;
      advance_min = 10'd10;
      left_gain = 11'd1101;
      right_gain = 11'd1203;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_unused();
      test_segment_walk();
      test_pulse_saturation();
      test_random_traffic();

      send_idle_pct = 0;
      stall_pct = 0;
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += expected_drives.size();

      $display("Sent %0d words over %0d register settings and four handshake patterns.",
               words_sent, RANDOM_PHASES + 2);
      $display("Checked %0d responses; steps %0d gentle, %0d normal, %0d sharp; %0d advances.",
               responses_checked, gentle_steps, normal_steps, sharp_steps,
               segment_advances);
      $display("Highest segment reached %0d, %0d mismatches.",
               highest_segment, mismatch_count);
      if (mismatch_count == 0) begin
         $display("line_follow_steering_sequencer test passed");
      end else begin
         $display("line_follow_steering_sequencer test failed");
      end
      $finish;
   end

endmodule
